/* rtl/wtd_pkg.sv */
// ----------------------------------------------------------------------------
// wtd_pkg
// Shared sizes, types and character codes for the word tokenizer with
// duplicate removal.
// ----------------------------------------------------------------------------
package wtd_pkg;

    // Table size and longest word kept
    localparam int TABLE_DEPTH  = 128;
    localparam int MAX_WORD_LEN = 32;

    // Derived widths
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    localparam int ROW_W = 8 * MAX_WORD_LEN;

    // Output field widths
    localparam int DIDX_W  = 7;
    localparam int DCNT_W  = 8;
    localparam int TOTAL_W = 16;

    // Separator characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef logic [7:0]       byte_t;
    typedef logic [LEN_W-1:0] len_t;

    // Control shared by every cell of the word chain
    typedef struct packed {
        logic  load_en;   // write din into the cell whose lane equals len
        logic  shift_en;  // take the byte of the next cell up
        byte_t din;
        len_t  len;       // current word length
    } cell_ctrl_t;

    function automatic logic is_separator(input byte_t c);
        return (c == CH_SPACE) || (c == CH_DOT) || (c == CH_COMMA) ||
               (c == CH_SEMI) || (c == CH_COLON) || (c == CH_LF) ||
               (c == CH_TAB);
    endfunction

endpackage

/* rtl/word_tokenize_dedup.sv */
// ----------------------------------------------------------------------------
// word_tokenize_dedup
// Splits a byte stream into words and sends each distinct word once, as a
// run of characters tagged with its table index, followed by totals at the
// end of the text.
//
//   channel  dir  tdata                                  tlast        tuser
//   s_       in   [7:0] text_byte                        end_of_text  -
//   m_       out  [7:0] out_char [14:8] distinct_index   word_end     [0] table_overflow
//                 [15] was_truncated [31:16] total_words              [1] summary_item
//                 [39:32] distinct_words
//
// A closing word is searched against every stored entry through the one
// registered read port; a new word then claims its entry, and its characters
// are sent one by one, or a single overflow result is sent instead; the
// totals result follows at end of text. Reset is synchronous, active low,
// and empties the table. Output stalls hold the character chain in place.
// ----------------------------------------------------------------------------
module word_tokenize_dedup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_char, distinct_index, was_truncated,
                                   // total_words, distinct_words
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // table_overflow, summary_item
);
    import wtd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_NEW,
        ST_EMIT,
        ST_OVF,
        ST_SUM
    } state_t;

    state_t             state_reg, state_next;
    len_t               len_reg, len_next;
    logic               trunc_reg, trunc_next;
    logic               eot_reg, eot_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]   widx_reg, widx_next;
    len_t               emit_reg, emit_next;

    logic               m_valid_reg, m_valid_next;
    byte_t              o_char_reg, o_char_next;
    logic               o_end_reg, o_end_next;
    logic [DIDX_W-1:0]  o_idx_reg, o_idx_next;
    logic               o_trunc_reg, o_trunc_next;
    logic               o_ovf_reg, o_ovf_next;
    logic               o_sum_reg, o_sum_next;
    logic [TOTAL_W-1:0] o_total_reg, o_total_next;
    logic [DCNT_W-1:0]  o_dcnt_reg, o_dcnt_next;

    cell_ctrl_t         cell_ctrl;
    byte_t              cell_bytes [MAX_WORD_LEN];
    logic [MAX_WORD_LEN-1:0] lane_ok;
    logic [ROW_W-1:0]   cur_row, rd_row;
    len_t               rd_len;
    logic               rd_en, wr_en, hit, out_free, in_acc;
    logic               sep;
    logic [IDX_W+DIDX_W-1:0] idx_ext;
    logic [CNT_W+DCNT_W-1:0] cnt_ext;

    // Chain of character cells
    for (genvar i = 0; i < MAX_WORD_LEN; i++) begin : g_cell
        byte_t nbr;
        if (i == MAX_WORD_LEN - 1) begin : g_top
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = cell_bytes[i+1];
        end
        assign cur_row[8*i +: 8] = cell_bytes[i];
        wtd_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .lane      (LEN_W'(i)),
            .nbr_byte  (nbr),
            .row_byte  (rd_row[8*i +: 8]),
            .cell_byte (cell_bytes[i]),
            .lane_ok   (lane_ok[i])
        );
    end

    wtd_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_row  (cur_row),
        .wr_len  (len_reg),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_row  (rd_row),
        .rd_len  (rd_len)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign sep      = is_separator(s_tdata);
    assign out_free = !m_valid_reg || m_tready;
    assign hit      = rd_valid_reg && (rd_len == len_reg) && (&lane_ok);
    assign rd_en    = (state_reg == ST_SEARCH) && (addr_reg < count_reg);
    assign wr_en    = (state_reg == ST_NEW) && (count_reg < CNT_W'(TABLE_DEPTH));

    assign idx_ext     = {{DIDX_W{1'b0}}, widx_reg};
    assign cnt_ext     = {{DCNT_W{1'b0}}, count_reg};

    // Next-state and datapath control
    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        trunc_next    = trunc_reg;
        eot_next      = eot_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        addr_next     = addr_reg;
        rd_valid_next = 1'b0;
        widx_next     = widx_reg;
        emit_next     = emit_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        o_char_next   = o_char_reg;
        o_end_next    = o_end_reg;
        o_idx_next    = o_idx_reg;
        o_trunc_next  = o_trunc_reg;
        o_ovf_next    = o_ovf_reg;
        o_sum_next    = o_sum_reg;
        o_total_next  = o_total_reg;
        o_dcnt_next   = o_dcnt_reg;

        cell_ctrl.load_en  = 1'b0;
        cell_ctrl.shift_en = 1'b0;
        cell_ctrl.din      = s_tdata;
        cell_ctrl.len      = len_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    eot_next = s_tlast;
                    if (!sep) begin
                        if (len_reg < LEN_W'(MAX_WORD_LEN)) begin
                            cell_ctrl.load_en = 1'b1;
                            len_next = len_reg + LEN_W'(1);
                        end else begin
                            trunc_next = 1'b1;
                        end
                    end
                    // Close a word on a separator or at end of text
                    if ((sep && (len_reg != '0)) || (!sep && s_tlast)) begin
                        if (total_reg != '1) begin
                            total_next = total_reg + TOTAL_W'(1);
                        end
                        addr_next  = '0;
                        state_next = ST_SEARCH;
                    end else if (s_tlast) begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SEARCH: begin
                // Issue one read a cycle, compare the previous one
                if (rd_en) begin
                    addr_next     = addr_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                end
                if (hit) begin
                    len_next   = '0;
                    trunc_next = 1'b0;
                    state_next = eot_reg ? ST_SUM : ST_IDLE;
                end else if (!rd_valid_reg && (addr_reg == count_reg)) begin
                    state_next = ST_NEW;
                end
            end
            ST_NEW: begin
                if (wr_en) begin
                    widx_next  = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_OVF;
                end
            end
            ST_EMIT: begin
                // Send lane zero and shift the word down
                if (out_free) begin
                    cell_ctrl.shift_en = 1'b1;
                    m_valid_next = 1'b1;
                    o_char_next  = cell_bytes[0];
                    o_end_next   = (emit_reg == len_reg - LEN_W'(1));
                    o_idx_next   = idx_ext[DIDX_W-1:0];
                    o_trunc_next = trunc_reg;
                    o_ovf_next   = 1'b0;
                    o_sum_next   = 1'b0;
                    o_total_next = total_reg;
                    o_dcnt_next  = cnt_ext[DCNT_W-1:0];
                    emit_next    = emit_reg + LEN_W'(1);
                    if (emit_reg == len_reg - LEN_W'(1)) begin
                        len_next   = '0;
                        trunc_next = 1'b0;
                        state_next = eot_reg ? ST_SUM : ST_IDLE;
                    end
                end
            end
            ST_OVF: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    o_char_next  = '0;
                    o_end_next   = 1'b0;
                    o_idx_next   = '0;
                    o_trunc_next = 1'b0;
                    o_ovf_next   = 1'b1;
                    o_sum_next   = 1'b0;
                    o_total_next = total_reg;
                    o_dcnt_next  = cnt_ext[DCNT_W-1:0];
                    len_next     = '0;
                    trunc_next   = 1'b0;
                    state_next   = eot_reg ? ST_SUM : ST_IDLE;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    o_char_next  = '0;
                    o_end_next   = 1'b0;
                    o_idx_next   = '0;
                    o_trunc_next = 1'b0;
                    o_ovf_next   = 1'b0;
                    o_sum_next   = 1'b1;
                    o_total_next = total_reg;
                    o_dcnt_next  = cnt_ext[DCNT_W-1:0];
                    eot_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            trunc_reg    <= 1'b0;
            eot_reg      <= 1'b0;
            count_reg    <= '0;
            total_reg    <= '0;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            trunc_reg    <= trunc_next;
            eot_reg      <= eot_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            addr_reg     <= addr_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        widx_reg    <= widx_next;
        emit_reg    <= emit_next;
        o_char_reg  <= o_char_next;
        o_end_reg   <= o_end_next;
        o_idx_reg   <= o_idx_next;
        o_trunc_reg <= o_trunc_next;
        o_ovf_reg   <= o_ovf_next;
        o_sum_reg   <= o_sum_next;
        o_total_reg <= o_total_next;
        o_dcnt_reg  <= o_dcnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {o_dcnt_reg, o_total_reg, o_trunc_reg, o_idx_reg, o_char_reg};
    assign m_tlast  = o_end_reg;
    assign m_tuser  = {o_sum_reg, o_ovf_reg};

endmodule

/* rtl/wtd_cell.sv */
// ----------------------------------------------------------------------------
// wtd_cell
// One character position of the open word: holds the byte, shifts toward
// lane zero while the word is sent out, and compares against its lane of a
// stored table row.
// ----------------------------------------------------------------------------
module wtd_cell (
    input  logic                aclk,
    input  wtd_pkg::cell_ctrl_t ctrl,
    input  wtd_pkg::len_t       lane,
    input  wtd_pkg::byte_t      nbr_byte,
    input  wtd_pkg::byte_t      row_byte,
    output wtd_pkg::byte_t      cell_byte,
    output logic                lane_ok
);
    import wtd_pkg::*;

    byte_t char_reg;

    // Load a new character or shift from the neighbor
    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            char_reg <= nbr_byte;
        end else if (ctrl.load_en && (lane == ctrl.len)) begin
            char_reg <= ctrl.din;
        end
    end

    assign cell_byte = char_reg;

    // Lanes past the word length always agree
    assign lane_ok = (lane >= ctrl.len) || (char_reg == row_byte);

endmodule

/* rtl/wtd_table.sv */
// ----------------------------------------------------------------------------
// wtd_table
// Distinct word store: one row of all character lanes per entry plus the
// entry length. One write port, one registered read port.
// ----------------------------------------------------------------------------
module wtd_table (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [wtd_pkg::IDX_W-1:0] wr_addr,
    input  logic [wtd_pkg::ROW_W-1:0] wr_row,
    input  wtd_pkg::len_t             wr_len,
    input  logic                      rd_en,
    input  logic [wtd_pkg::IDX_W-1:0] rd_addr,
    output logic [wtd_pkg::ROW_W-1:0] rd_row,
    output wtd_pkg::len_t             rd_len
);
    import wtd_pkg::*;

    logic [ROW_W-1:0] row_mem [TABLE_DEPTH];
    len_t             len_mem [TABLE_DEPTH];

    // Store a new word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_row;
            len_mem[wr_addr] <= wr_len;
        end
    end

    // Read one entry per cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row <= row_mem[rd_addr];
            rd_len <= len_mem[rd_addr];
        end
    end

endmodule

/* verif/word_tokenize_dedup_test.sv */
// ----------------------------------------------------------------------------
// word_tokenize_dedup_test
// Self-checking bench for the word tokenizer with duplicate removal. A
// directed script covers byte extremes, every separator, repeats, case,
// overlong words and end of text. Random text from a small vocabulary
// follows. Every result is checked field by field against a behavioral
// model of the tokenizer, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module word_tokenize_dedup_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wtd_pkg::*;

    localparam int VOCAB_N   = 10;
    localparam int TOTAL_MAX = 65535;

    // One result of the block, in the order of the result fields
    typedef struct packed {
        byte_t       out_char;
        logic        word_end;
        logic [6:0]  didx;
        logic        cut;
        logic        ovf;
        logic        summ;
        logic [15:0] total;
        logic [7:0]  distinct;
    } word_res_t;

    // One row of the directed script
    typedef struct {
        byte_t     chr;
        logic      eot;
        int        reps;
        bit        typed;
        word_res_t want;
    } text_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] text_byte
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [7:0] out_char, [14:8] distinct_index,
                                    // [15] was_truncated, [31:16] total_words,
                                    // [39:32] distinct_words
    logic        m_tlast;
    logic [1:0]  m_tuser;           // [0] table_overflow, [1] summary_item

    // Model state: distinct table, open word and counters
    byte_t     dict_chr [TABLE_DEPTH][MAX_WORD_LEN];
    int        dict_len [TABLE_DEPTH];
    byte_t     open_word[$];
    bit        open_cut = 1'b0;
    int        n_stored = 0;
    int        n_total = 0;

    // Results of the last item, and results still owed by the block
    word_res_t fresh_res[$];
    word_res_t pending_res[$];

    byte_t     draft[$];
    byte_t     vocab_chr [VOCAB_N][MAX_WORD_LEN + 8];
    int        vocab_len [VOCAB_N];
    text_row_t script[$];

    int        errors = 0;
    int        sent_items = 0;
    int        burst_left = 0;
    int        rx_hold = 0;
    logic [15:0] rx_cycle = '0;
    word_res_t want_res;

    word_tokenize_dedup dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit splits_word(input byte_t c);
        case (c)
            CH_SPACE, CH_DOT, CH_COMMA, CH_SEMI, CH_COLON, CH_LF, CH_TAB: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic word_res_t pack_res(input byte_t ch, input logic fin, input int idx,
                                           input logic cut, input logic ovf, input logic summ,
                                           input int total, input int distinct);
        word_res_t r;
        r.out_char = ch;
        r.word_end = fin;
        r.didx     = idx[6:0];
        r.cut      = cut;
        r.ovf      = ovf;
        r.summ     = summ;
        r.total    = total[15:0];
        r.distinct = distinct[7:0];
        return r;
    endfunction

    // Tag a result with the counts as they stand now
    function automatic word_res_t count_res(input byte_t ch, input logic fin, input int idx,
                                            input logic cut, input logic ovf, input logic summ);
        return pack_res(ch, fin, idx, cut, ovf, summ, n_total, n_stored);
    endfunction

    // Table position of a word, or -1 when it is not stored
    function automatic int dict_lookup(input byte_t w[$]);
        for (int e = 0; e < n_stored; e++) begin
            if (dict_len[e] == w.size()) begin
                bit same;
                same = 1'b1;
                for (int i = 0; i < w.size(); i++) begin
                    if (dict_chr[e][i] != w[i]) same = 1'b0;
                end
                if (same) return e;
            end
        end
        return -1;
    endfunction

    // Count the open word, then store and emit it if it is new
    task automatic close_open();
        int idx;
        if (open_word.size() == 0) return;
        if (n_total < TOTAL_MAX) n_total++;
        if (dict_lookup(open_word) < 0) begin
            if (n_stored >= TABLE_DEPTH) begin
                fresh_res.push_back(count_res(8'h00, 1'b0, 0, 1'b0, 1'b1, 1'b0));
            end else begin
                idx = n_stored;
                for (int i = 0; i < open_word.size(); i++) dict_chr[idx][i] = open_word[i];
                dict_len[idx] = open_word.size();
                n_stored++;
                for (int i = 0; i < open_word.size(); i++) begin
                    fresh_res.push_back(count_res(open_word[i], i == open_word.size() - 1,
                                                  idx, open_cut, 1'b0, 1'b0));
                end
            end
        end
        open_word.delete();
        open_cut = 1'b0;
    endtask

    // Take one text byte into the model
    task automatic tokenize_byte(input byte_t c, input logic eot);
        if (splits_word(c)) begin
            close_open();
        end else if (open_word.size() < MAX_WORD_LEN) begin
            open_word.push_back(c);
        end else begin
            open_cut = 1'b1;
        end
        if (eot) begin
            close_open();
            fresh_res.push_back(count_res(8'h00, 1'b0, 0, 1'b0, 1'b0, 1'b1));
        end
    endtask

    // Send one item in bursts with random gaps, then predict its results
    task automatic send_item(input byte_t c, input logic eot, input bit commit);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sent_items++;
        tokenize_byte(c, eot);
        if (commit) begin
            while (fresh_res.size() > 0) pending_res.push_back(fresh_res.pop_front());
        end
    endtask

    function automatic byte_t pick_letter();
        byte_t c;
        do c = byte_t'($urandom_range(0, 255)); while (splits_word(c));
        return c;
    endfunction

    function automatic byte_t pick_split();
        case ($urandom_range(0, 6))
            0: return CH_SPACE;
            1: return CH_DOT;
            2: return CH_COMMA;
            3: return CH_SEMI;
            4: return CH_COLON;
            5: return CH_LF;
            default: return CH_TAB;
        endcase
    endfunction

    task automatic make_word(input int n);
        for (int i = 0; i < n; i++) draft.push_back(pick_letter());
    endtask

    task automatic load_vocab(input int k);
        draft.delete();
        for (int i = 0; i < vocab_len[k]; i++) draft.push_back(vocab_chr[k][i]);
    endtask

    task automatic send_draft(input logic eot_last);
        for (int i = 0; i < draft.size(); i++) begin
            send_item(draft[i], eot_last && (i == draft.size() - 1), 1'b1);
        end
    endtask

    // Random text: mostly vocabulary words, some new, overlong and noisy
    task automatic run_text(input int n_items);
        int  stop_at;
        int  pick;
        int  n_sep;
        bit  eot_now;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            pick = $urandom_range(0, 99);
            draft.delete();
            if (pick < 55) begin
                load_vocab($urandom_range(0, VOCAB_N - 1));
            end else if (pick < 72) begin
                make_word($urandom_range(1, 6));
            end else if (pick < 78) begin
                make_word($urandom_range(MAX_WORD_LEN - 1, MAX_WORD_LEN + 5));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) draft.push_back(byte_t'($urandom_range(0, 255)));
            end
            eot_now = ($urandom_range(0, 11) == 0);
            n_sep = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1;
            if (eot_now && $urandom_range(0, 2) == 0) n_sep = 0;
            if (draft.size() == 0 && n_sep == 0) n_sep = 1;
            send_draft(eot_now && n_sep == 0);
            for (int i = 0; i < n_sep; i++) send_item(pick_split(), eot_now && i == n_sep - 1, 1'b1);
        end
    endtask

    function automatic text_row_t row(input byte_t c, input logic eot, input int reps);
        text_row_t t;
        t.chr   = c;
        t.eot   = eot;
        t.reps  = reps;
        t.typed = 1'b0;
        t.want  = '0;
        return t;
    endfunction

    function automatic text_row_t typed_row(input byte_t c, input logic eot,
                                            input word_res_t want);
        text_row_t t;
        t = row(c, eot, 1);
        t.typed = 1'b1;
        t.want  = want;
        return t;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Receiver: random stalls, with a stall-free window while rx_cycle[9:8] is 2'b11
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_cycle[9:8] == 2'b11) begin
            m_tready <= 1'b1;
        end else if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_res.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual tdata %h tlast %b tuser %b",
                         $time, m_tdata, m_tlast, m_tuser);
            end else begin
                want_res = pending_res.pop_front();
                check_field("out_char",       want_res.out_char, m_tdata[7:0]);
                check_field("word_end",       want_res.word_end, m_tlast);
                check_field("distinct_index", want_res.didx,     m_tdata[14:8]);
                check_field("was_truncated",  want_res.cut,      m_tdata[15]);
                check_field("table_overflow", want_res.ovf,      m_tuser[0]);
                check_field("summary_item",   want_res.summ,     m_tuser[1]);
                check_field("total_words",    want_res.total,    m_tdata[31:16]);
                check_field("distinct_words", want_res.distinct, m_tdata[39:32]);
            end
        end
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed script: empty text, extremes, separators, repeats, case, overlong
        script.push_back(typed_row(CH_SPACE, 1'b1,
                                   pack_res(8'h00, 1'b0, 0, 1'b0, 1'b0, 1'b1, 0, 0)));
        script.push_back(row("x", 1'b0, 1));
        script.push_back(typed_row(CH_DOT, 1'b0,
                                   pack_res("x", 1'b1, 0, 1'b0, 1'b0, 1'b0, 1, 1)));
        script.push_back(row(8'hFF, 1'b0, 1));
        script.push_back(row(8'h00, 1'b0, 1));
        script.push_back(row(CH_TAB, 1'b0, 1));
        script.push_back(row("x", 1'b0, 1));
        script.push_back(row(CH_COMMA, 1'b0, 1));
        script.push_back(row(CH_SEMI, 1'b0, 1));
        script.push_back(row("X", 1'b0, 1));
        script.push_back(row(CH_SPACE, 1'b0, 1));
        script.push_back(row("q", 1'b0, MAX_WORD_LEN + 2));
        script.push_back(row(CH_COLON, 1'b0, 1));
        script.push_back(row("q", 1'b0, MAX_WORD_LEN + 1));
        script.push_back(row(CH_LF, 1'b0, 1));
        script.push_back(row(8'h80, 1'b1, 1));
        script.push_back(row(CH_DOT, 1'b1, 1));
        script.push_back(row("x", 1'b1, 1));
        foreach (script[r]) begin
            repeat (script[r].reps) begin
                send_item(script[r].chr, script[r].eot, !script[r].typed);
                if (script[r].typed) begin
                    fresh_res.delete();
                    pending_res.push_back(script[r].want);
                end
            end
        end

        // Vocabulary: a word, its extension, its case twin, an overlong word
        vocab_len[0] = $urandom_range(1, 5);
        for (int i = 0; i < vocab_len[0]; i++) begin
            vocab_chr[0][i] = byte_t'(8'h61 + $urandom_range(0, 25));
        end
        vocab_len[1] = vocab_len[0] + 1;
        vocab_len[2] = vocab_len[0];
        for (int i = 0; i < vocab_len[0]; i++) begin
            vocab_chr[1][i] = vocab_chr[0][i];
            vocab_chr[2][i] = vocab_chr[0][i];
        end
        vocab_chr[1][vocab_len[0]] = pick_letter();
        vocab_chr[2][0] = vocab_chr[0][0] ^ 8'h20;
        vocab_len[3] = MAX_WORD_LEN + 3;
        for (int i = 0; i < vocab_len[3]; i++) vocab_chr[3][i] = pick_letter();
        for (int k = 4; k < VOCAB_N; k++) begin
            vocab_len[k] = $urandom_range(1, 6);
            for (int i = 0; i < vocab_len[k]; i++) vocab_chr[k][i] = pick_letter();
        end

        run_text(88);

        // Drain: wait for every owed result, then watch for strays
        s_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
